// ===== rtl/gls_pkg.sv =====
package gls_pkg;

   localparam int MAX_GRID = 1024;
   localparam int IDX_W    = $clog2(MAX_GRID);
   localparam int ESZ_W    = $clog2(MAX_GRID + 1);
   localparam int GRID_W   = 11;
   localparam int LIMIT_W  = 32;
   localparam int CSR_W    = 32;
   localparam int MIN_GRID = 3;

   localparam logic [LIMIT_W-1:0] GEN_MAX = {LIMIT_W{1'b1}};

   // register indexes
   localparam logic CSR_GRID_SIZE = 1'b0;
   localparam logic CSR_GEN_LIMIT = 1'b1;

   typedef struct packed {
      logic cell_alive;
      logic frame_start;
   } req_word_type;

   typedef struct packed {
      logic               next_alive;
      logic               cell_changed;
      logic               frame_last;
      logic               frame_changed;
      logic [LIMIT_W-1:0] generation_number;
      logic               run_over;
   } rsp_word_type;

   // one raster position, registered after the counters
   typedef struct packed {
      logic             alive;
      logic             fs;
      logic [IDX_W-1:0] idx;
      logic             emit;
      logic             last;
   } stage_type;

   // two line buffer bits of one column: [0] older row, [1] newer row
   typedef logic [1:0] line_bits_type;

   function automatic logic [ESZ_W-1:0] effective_size(input logic [GRID_W-1:0] g);
      if (32'(g) < MIN_GRID)
         return ESZ_W'(MIN_GRID);
      else if (32'(g) > MAX_GRID)
         return ESZ_W'(MAX_GRID);
      else
         return ESZ_W'(g);
   endfunction

endpackage

// ===== rtl/gls_ram.sv =====
module gls_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gls_raster.sv =====
module gls_raster (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        advance,
   input  gls_pkg::req_word_type       req_word,
   input  logic [gls_pkg::ESZ_W-1:0]   size,
   output logic [gls_pkg::IDX_W-1:0]   rd_addr,
   output logic                        stage_valid,
   output gls_pkg::stage_type          stage
);

   logic [gls_pkg::IDX_W-1:0] col_ff, col_in;
   logic [gls_pkg::IDX_W-1:0] row_ff, row_in;
   logic                      valid_ff, valid_in;
   gls_pkg::stage_type        stage_ff, stage_in;

   logic [gls_pkg::IDX_W-1:0] c, r;
   logic [gls_pkg::ESZ_W-1:0] c_ext, r_ext, c_inc, r_inc;

   always_comb begin
      c      = req_word.frame_start ? '0 : col_ff;
      r      = req_word.frame_start ? '0 : row_ff;
      c_ext  = gls_pkg::ESZ_W'(c);
      r_ext  = gls_pkg::ESZ_W'(r);
      c_inc  = c_ext + gls_pkg::ESZ_W'(1);
      r_inc  = r_ext + gls_pkg::ESZ_W'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c_inc >= size) begin
            col_in = '0;
            row_in = (r_inc >= size) ? '0 : gls_pkg::IDX_W'(r_inc);
         end else begin
            col_in = gls_pkg::IDX_W'(c_inc);
            row_in = r;
         end
      end
      stage_in.alive = req_word.cell_alive;
      stage_in.fs    = req_word.frame_start;
      stage_in.idx   = c;
      stage_in.emit  = (r_ext >= gls_pkg::ESZ_W'(2)) && (c_ext >= gls_pkg::ESZ_W'(2))
                       && (r_ext < size) && (c_ext < size);
      stage_in.last  = (r_ext == size - gls_pkg::ESZ_W'(1))
                       && (c_ext == size - gls_pkg::ESZ_W'(1));
      valid_in = accept | (valid_ff & ~advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign rd_addr     = c;
   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

// ===== rtl/gls_rule.sv =====
module gls_rule (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  gls_pkg::stage_type            stage,
   input  gls_pkg::line_bits_type        line_bits,
   input  logic [gls_pkg::LIMIT_W-1:0]   generation_limit,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output gls_pkg::rsp_word_type         rsp_word,
   output logic                          wr_en,
   output logic [gls_pkg::IDX_W-1:0]     wr_addr,
   output gls_pkg::line_bits_type        wr_data
);

   logic [2:0]                   window_ff [3];
   logic [2:0]                   window_in [3];
   logic                         any_ff, any_in;
   logic [gls_pkg::LIMIT_W-1:0]  gen_ff, gen_in;
   logic                         valid_ff, valid_in;
   gls_pkg::rsp_word_type        word_ff, word_in;

   logic [3:0]                   sum9, n;
   logic                         center, next, chg, any_eff, fchg, over;
   logic [gls_pkg::LIMIT_W-1:0]  gen;

   function automatic logic [3:0] ones3(input logic [2:0] v);
      return {3'b000, v[0]} + {3'b000, v[1]} + {3'b000, v[2]};
   endfunction

   always_comb begin
      // shifted window: columns x-2, x-1, x
      window_in[0] = window_ff[1];
      window_in[1] = window_ff[2];
      window_in[2] = {stage.alive, line_bits[1], line_bits[0]};

      center = window_in[1][1];
      sum9   = ones3(window_in[0]) + ones3(window_in[1]) + ones3(window_in[2]);
      n      = sum9 - {3'b000, center};
      next   = center ? ((n == 4'd2) || (n == 4'd3)) : (n == 4'd3);
      chg    = next ^ center;

      any_eff = stage.fs ? 1'b0 : any_ff;
      fchg    = any_eff | chg;
      gen     = (gen_ff == gls_pkg::GEN_MAX) ? gls_pkg::GEN_MAX
                                              : gen_ff + gls_pkg::LIMIT_W'(1);
      over    = ~fchg || ((generation_limit != '0) && (gen >= generation_limit));

      word_in.next_alive        = next;
      word_in.cell_changed      = chg;
      word_in.frame_last        = stage.last;
      word_in.frame_changed     = stage.last & fchg;
      word_in.generation_number = gen;
      word_in.run_over          = stage.last & over;

      any_in = any_ff;
      gen_in = gen_ff;
      if (advance) begin
         if (stage.emit) begin
            any_in = stage.last ? 1'b0 : fchg;
            if (stage.last) begin
               gen_in = gen;
            end
         end else begin
            any_in = any_eff;
         end
      end

      valid_in = (advance & stage.emit) | (valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff[0] <= '0;
         window_ff[1] <= '0;
         window_ff[2] <= '0;
         any_ff       <= 1'b0;
         gen_ff       <= '0;
         valid_ff     <= 1'b0;
      end else begin
         if (advance) begin
            window_ff[0] <= window_in[0];
            window_ff[1] <= window_in[1];
            window_ff[2] <= window_in[2];
         end
         any_ff   <= any_in;
         gen_ff   <= gen_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance & stage.emit) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;
   assign wr_en     = advance;
   assign wr_addr   = stage.idx;
   // older row takes the newer bit, newer row takes the incoming cell
   assign wr_data   = {stage.alive, line_bits[1]};

`ifndef SYNTHESIS
   a_flags_only_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !word_ff.frame_last |-> !word_ff.frame_changed && !word_ff.run_over)
      else $error("frame flags set on a word that is not frame last");

   a_gen_step: assert property (@(posedge clock) disable iff (reset)
      advance && stage.emit && stage.last && gen_ff != gls_pkg::GEN_MAX
      |=> gen_ff == $past(gen_ff) + gls_pkg::LIMIT_W'(1))
      else $error("generation count did not step on frame last");

   a_gen_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && stage.emit && stage.last) |=> $stable(gen_ff))
      else $error("generation count moved outside frame last");

   a_stable_over: assert property (@(posedge clock) disable iff (reset)
      valid_ff && word_ff.frame_last && !word_ff.frame_changed |-> word_ff.run_over)
      else $error("unchanged frame not reported as run over");
`endif

endmodule

// ===== rtl/life_generation_stencil_core.sv =====
// channel   handshake             payload
// req       req_valid/req_stall   req_word   cell_alive, frame_start
// rsp       rsp_valid/rsp_stall   rsp_word   next_alive .. run_over
// csr       csr_wr_en             csr_index, csr_wdata
//
// one word per cycle sustained while rsp is not stalled: counters and line buffer
// read in the first stage, window shift, neighbor count and rule in the second,
// then the output register.
// no clearing pass after reset; line buffers are valid once a row is written.
// a stall on rsp holds the output register and backs up into req_stall.
module life_generation_stencil_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gls_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gls_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [gls_pkg::CSR_W-1:0]     csr_wdata
);

   logic [gls_pkg::GRID_W-1:0]   grid_size_ff;
   logic [gls_pkg::LIMIT_W-1:0]  gen_limit_ff;
   logic                         byp_ff, byp_in;
   gls_pkg::line_bits_type       byp_data_ff;

   logic                         accept, advance, stage_valid;
   logic [gls_pkg::ESZ_W-1:0]    size;
   logic [gls_pkg::IDX_W-1:0]    rd_addr, wr_addr;
   gls_pkg::stage_type           stage;
   gls_pkg::line_bits_type       ram_rd_data, line_bits, wr_data;
   logic                         wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= gls_pkg::GRID_W'(1024);
         gen_limit_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            gls_pkg::CSR_GRID_SIZE: grid_size_ff <= csr_wdata[gls_pkg::GRID_W-1:0];
            gls_pkg::CSR_GEN_LIMIT: gen_limit_ff <= csr_wdata[gls_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign size      = gls_pkg::effective_size(grid_size_ff);
   assign advance   = stage_valid & (~rsp_valid | ~rsp_stall);
   assign req_stall = stage_valid & ~advance;
   assign accept    = req_valid & ~req_stall;

   // a read of the column being written in the same cycle takes the new bits
   assign byp_in    = accept ? (advance && (rd_addr == wr_addr)) : byp_ff;
   assign line_bits = byp_ff ? byp_data_ff : ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byp_data_ff <= wr_data;
      end
   end

   gls_raster u_raster (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .advance     (advance),
      .req_word    (req_word),
      .size        (size),
      .rd_addr     (rd_addr),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   gls_ram #(
      .WIDTH (2),
      .DEPTH (gls_pkg::MAX_GRID)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   gls_rule u_rule (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .stage            (stage),
      .line_bits        (line_bits),
      .generation_limit (gen_limit_ff),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_word         (rsp_word),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

endmodule
